### rtl/swmf_pkg.sv
// Shared types and constants for the sliding window median filter.
// No dependencies; every other file of the block but swmf_ram imports this package.
package swmf_pkg;

	localparam int DATA_W = 16;
	localparam int CNT_W  = 7;
	localparam int SLOT_W = 6;
	localparam int WL_W   = 8;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef logic [DATA_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]  count_t;

	// Request from the history control to the rank selector.
	typedef struct packed {
		logic   start;
		count_t count;
	} swmf_sel_req_t;

	// Answer from the rank selector.
	typedef struct packed {
		logic    done;
		sample_t median;
	} swmf_sel_rsp_t;

endpackage

### rtl/swmf_if.sv
// Valid/ready channel interfaces for samples, results and the window register.
// Depends on swmf_pkg for the payload widths.
interface swmf_in_if import swmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [DATA_W-1:0]     reading;
	modport source (output valid, output opcode, output reading, input ready);
	modport sink   (input valid, input opcode, input reading, output ready);
endinterface

interface swmf_out_if import swmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DATA_W-1:0]     median_mv;
	logic [CNT_W-1:0]      samples_held;
	modport source (output valid, output median_mv, output samples_held, input ready);
	modport sink   (input valid, input median_mv, input samples_held, output ready);
endinterface

interface swmf_cfg_if import swmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [WL_W-1:0]       window_length;
	modport source (output valid, output window_length, input ready);
	modport sink   (input valid, input window_length, output ready);
endinterface

### rtl/swmf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/swmf_rank.sv
// Rank selector: finds the median of the first n ring entries with one shared pair
// of comparators, counting for each candidate the entries below and not above it.
// Depends on swmf_pkg; reads the ring through a registered-read RAM port.
module swmf_rank import swmf_pkg::*; #(
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  swmf_sel_req_t req,
	output swmf_sel_rsp_t rsp,
	output logic [AW-1:0] rd_addr,
	input  sample_t       rd_data
);
	localparam logic [2:0] R_IDLE   = 3'd0;
	localparam logic [2:0] R_CRD    = 3'd1;
	localparam logic [2:0] R_CLAT   = 3'd2;
	localparam logic [2:0] R_SWEEP  = 3'd3;
	localparam logic [2:0] R_DECIDE = 3'd4;
	localparam logic [2:0] R_FINAL  = 3'd5;

	logic [2:0]  state_q;
	count_t      n_q, i_q, j_q, lt_q, le_q;
	sample_t     cand_q, lo_q, hi_q;
	count_t      k_lo, k_hi;
	logic [DATA_W:0] sum;

	assign k_lo = (n_q - 7'd1) >> 1;
	assign k_hi = n_q >> 1;
	assign sum  = {1'b0, lo_q} + {1'b0, hi_q};

	assign rd_addr    = (state_q == R_CRD) ? i_q[AW-1:0] : j_q[AW-1:0];
	assign rsp.done   = (state_q == R_FINAL);
	assign rsp.median = sum[DATA_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			lt_q    <= '0;
			le_q    <= '0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					if (req.start) begin
						n_q     <= req.count;
						i_q     <= '0;
						state_q <= R_CRD;
					end
				end
				R_CRD: begin
					j_q     <= '0;
					lt_q    <= '0;
					le_q    <= '0;
					state_q <= R_CLAT;
				end
				R_CLAT: begin
					// candidate arrives; entry 0 is addressed now
					j_q     <= 7'd1;
					state_q <= R_SWEEP;
				end
				R_SWEEP: begin
					// data here belongs to entry j_q - 1
					if (rd_data < cand_q) begin
						lt_q <= lt_q + 7'd1;
					end
					if (rd_data <= cand_q) begin
						le_q <= le_q + 7'd1;
					end
					if (j_q == n_q) begin
						state_q <= R_DECIDE;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end
				R_DECIDE: begin
					if (i_q == n_q - 7'd1) begin
						state_q <= R_FINAL;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= R_CRD;
					end
				end
				R_FINAL: begin
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == R_CLAT) begin
			cand_q <= rd_data;
		end
		if (state_q == R_DECIDE) begin
			if (lt_q <= k_lo && k_lo < le_q) begin
				lo_q <= cand_q;
			end
			if (lt_q <= k_hi && k_hi < le_q) begin
				hi_q <= cand_q;
			end
		end
	end
endmodule

### rtl/sliding_window_median_filter_unit.sv
// Sliding window median filter: the time a push takes is set by the rank
// selector, which walks every held sample once per candidate through the
// ring RAM's single read port and one pair of comparators; a clear skips
// the rank selector. The sample port is not ready while an item is in
// work. A result register parts the output side, so a finished result may
// wait while the block sits idle. Writing window_length empties the
// history, like a clear beat.
// Depends on swmf_pkg, the channel interfaces, swmf_ram and swmf_rank.
module sliding_window_median_filter_unit import swmf_pkg::*; #(
	parameter int WINDOW_MAX     = 16,
	parameter int WINDOW_DEFAULT = 8
) (
	input  logic clk,
	input  logic arst_n,
	swmf_in_if.sink    samples,
	swmf_out_if.source results,
	swmf_cfg_if.sink   cfg
);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_BUSY = 2'd1;
	localparam logic [1:0] T_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [WL_W-1:0]   wl_q;
	logic [SLOT_W-1:0] slot_q;
	count_t            count_q;
	sample_t           med_q;
	logic              out_vld_q;
	sample_t           out_med_q;
	count_t            out_cnt_q;

	count_t            len;
	logic [SLOT_W-1:0] slot_eff;
	count_t            slot_inc;
	logic [SLOT_W-1:0] slot_next;
	count_t            count_next;
	logic              in_acc, cfg_acc, push, emit;
	logic [AW-1:0]     rd_addr;
	sample_t           rd_data;
	swmf_sel_req_t     sel_req;
	swmf_sel_rsp_t     sel_rsp;

	assign len = (wl_q == '0 || wl_q > WL_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_DEFAULT)
		: wl_q[CNT_W-1:0];
	assign slot_eff   = ({1'b0, slot_q} >= len) ? '0 : slot_q;
	assign slot_inc   = {1'b0, slot_eff} + 7'd1;
	assign slot_next  = (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
	assign count_next = (count_q < len) ? count_q + 7'd1 : count_q;

	assign cfg.ready     = (state_q == T_IDLE);
	assign samples.ready = (state_q == T_IDLE) && !cfg.valid;
	assign cfg_acc       = cfg.valid && cfg.ready;
	assign in_acc        = samples.valid && samples.ready;
	assign push          = in_acc && (samples.opcode == OP_PUSH);
	assign emit          = (state_q == T_EMIT) && (!out_vld_q || results.ready);

	assign sel_req.start = push;
	assign sel_req.count = count_next;

	assign results.valid        = out_vld_q;
	assign results.median_mv    = out_med_q;
	assign results.samples_held = out_cnt_q;

	swmf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (push),
		.waddr(slot_eff[AW-1:0]),
		.wdata(samples.reading),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	swmf_rank #(
		.AW(AW)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sel_req),
		.rsp    (sel_rsp),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			wl_q      <= '0;
			slot_q    <= '0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (cfg_acc) begin
						wl_q    <= cfg.window_length;
						slot_q  <= '0;
						count_q <= '0;
					end else if (in_acc) begin
						if (samples.opcode == OP_CLEAR) begin
							slot_q  <= '0;
							count_q <= '0;
							state_q <= T_EMIT;
						end else begin
							slot_q  <= slot_next;
							count_q <= count_next;
							state_q <= T_BUSY;
						end
					end
				end
				T_BUSY: begin
					if (sel_rsp.done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (emit) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && samples.opcode == OP_CLEAR) begin
			med_q <= '0;
		end else if (state_q == T_BUSY && sel_rsp.done) begin
			med_q <= sel_rsp.median;
		end
		if (emit) begin
			out_med_q <= med_q;
			out_cnt_q <= count_q;
		end
	end
endmodule

### rtl/swmf_checker.sv
// Port-level assertions for the sliding window median filter, and the bind
// that attaches them to the top level. Depends on swmf_pkg.
module swmf_checker import swmf_pkg::*; #(
	parameter int WINDOW_MAX = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input sample_t       median_mv,
	input count_t        samples_held
);
	// an accepted sample beat takes the block out of idle and drops the sample port's ready
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample port ready right after an accepted beat");

	a_empty_median_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && samples_held == '0 |-> median_mv == '0)
		else $error("nonzero median with no samples held");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> samples_held <= CNT_W'(WINDOW_MAX))
		else $error("samples_held above window maximum");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_mv)
			&& $stable(samples_held))
		else $error("stalled result beat changed or dropped");
endmodule

bind sliding_window_median_filter_unit swmf_checker #(
	.WINDOW_MAX(WINDOW_MAX)
) u_swmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.median_mv   (results.median_mv),
	.samples_held(results.samples_held)
);

### tb/swmf_median_check.sv
`timescale 1ns / 100ps
// Watches the sample, result and window channels of the median filter,
// keeps its own copy of the sample history and checks every result beat.
// Depends on swmf_pkg for widths and opcodes.
module swmf_median_check import swmf_pkg::*; #(
	parameter int WINDOW_MAX     = 16,
	parameter int WINDOW_DEFAULT = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic            in_opcode,
	input  sample_t         in_sample,
	input  logic            out_valid,
	input  logic            out_ready,
	input  sample_t         out_median,
	input  count_t          out_held,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [WL_W-1:0] cfg_length,
	output int              mismatches,
	output int              pending
);

	typedef struct {
		sample_t median;
		count_t  held;
	} median_result_t;

	median_result_t  median_due[$];
	sample_t         ring_copy [WINDOW_MAX];
	int unsigned     next_slot;
	int unsigned     held_now;
	logic [WL_W-1:0] window_reg;

	function automatic int unsigned active_length();
		if (window_reg == '0 || window_reg > WINDOW_MAX)
			return WINDOW_DEFAULT;
		return window_reg;
	endfunction

	// Sort the held samples and take the middle one, or the floored mean
	// of the two middle ones for an even count.
	function automatic sample_t median_of_ring();
		sample_t         sorted [WINDOW_MAX];
		sample_t         v;
		int unsigned     n;
		int              k;
		logic [DATA_W:0] pair;
		n = held_now;
		if (n == 0)
			return '0;
		for (int i = 0; i < n; i++)
			sorted[i] = ring_copy[i];
		for (int i = 1; i < n; i++) begin
			v = sorted[i];
			k = i;
			while (k > 0 && sorted[k-1] > v) begin
				sorted[k] = sorted[k-1];
				k--;
			end
			sorted[k] = v;
		end
		if (n % 2 == 1)
			return sorted[n/2];
		pair = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
		return pair[DATA_W:1];
	endfunction

	function automatic median_result_t predict_median(input logic op, input sample_t smp);
		median_result_t r;
		int unsigned    len;
		if (op == OP_CLEAR) begin
			next_slot = 0;
			held_now  = 0;
			r.median  = '0;
			r.held    = '0;
			return r;
		end
		len = active_length();
		if (next_slot >= len)
			next_slot = 0;
		ring_copy[next_slot] = smp;
		if (held_now < len)
			held_now++;
		next_slot++;
		if (next_slot >= len)
			next_slot = 0;
		r.median = median_of_ring();
		r.held   = count_t'(held_now);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		median_result_t got;
		median_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_MAX; i++)
				ring_copy[i] = '0;
			next_slot  = 0;
			held_now   = 0;
			window_reg = '0;
			median_due.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_reg = cfg_length;
				next_slot  = 0;
				held_now   = 0;
			end
			// compare the result beat before queueing a new sample beat
			if (out_valid && out_ready) begin
				got.median = out_median;
				got.held   = out_held;
				if (median_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none due: median %0d held %0d",
							$realtime, got.median, got.held);
					mismatches <= mismatches + 1;
				end else begin
					want = median_due.pop_front();
					if (got.median !== want.median || got.held !== want.held) begin
						if (mismatches < 10)
							$display("%0t: median %0d held %0d, expected median %0d held %0d",
								$realtime, got.median, got.held, want.median, want.held);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready)
				median_due.push_back(predict_median(in_opcode, in_sample));
			pending <= median_due.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the median filter testbench: clock, reset, sample and window stimulus,
// result back-pressure and the verdict. Depends on swmf_pkg, the channel
// interfaces, the filter unit and swmf_median_check.
module testbench;
	import swmf_pkg::*;

	localparam int WINDOW_MAX     = 16;
	localparam int WINDOW_DEFAULT = 8;
	localparam int RANDOM_ITEMS   = 1530;
	localparam int CYCLE_LIMIT    = 3000000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   burst_left;
	int   hold_asks;
	int   cycles;

	swmf_in_if  s_if ();
	swmf_out_if r_if ();
	swmf_cfg_if c_if ();

	sliding_window_median_filter_unit #(
		.WINDOW_MAX    (WINDOW_MAX),
		.WINDOW_DEFAULT(WINDOW_DEFAULT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(s_if),
		.results(r_if),
		.cfg    (c_if)
	);

	swmf_median_check #(
		.WINDOW_MAX    (WINDOW_MAX),
		.WINDOW_DEFAULT(WINDOW_DEFAULT)
	) check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_if.valid),
		.in_ready  (s_if.ready),
		.in_opcode (s_if.opcode),
		.in_sample (s_if.reading),
		.out_valid (r_if.valid),
		.out_ready (r_if.ready),
		.out_median(r_if.median_mv),
		.out_held  (r_if.samples_held),
		.cfg_valid (c_if.valid),
		.cfg_ready (c_if.ready),
		.cfg_length(c_if.window_length),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Result side: stall patterns of its own, plus a long hold-off on request.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int hold_seen;
		r_if.ready = 1'b0;
		mode       = 0;
		mode_left  = 0;
		hold_left  = 0;
		hold_seen  = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = 3000;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 600);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				r_if.ready <= 1'b0;
			end else begin
				case (mode)
				0: r_if.ready <= 1'b1;
				1: r_if.ready <= ($urandom_range(0, 1) == 1);
				2: r_if.ready <= ($urandom_range(0, 4) == 0);
				default: r_if.ready <= (mode_left % 7 == 0);
				endcase
			end
		end
	end

	task automatic put_item(input logic op, input sample_t smp);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				s_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_if.valid   <= 1'b1;
		s_if.opcode  <= op;
		s_if.reading <= smp;
		@(posedge clk);
		while (!s_if.ready) @(posedge clk);
		burst_left--;
	endtask

	// Drop valid and wait until every due result has been taken.
	task automatic settle();
		s_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_window(input logic [WL_W-1:0] len);
		settle();
		c_if.valid         <= 1'b1;
		c_if.window_length <= len;
		@(posedge clk);
		while (!c_if.ready) @(posedge clk);
		c_if.valid <= 1'b0;
	endtask

	function automatic logic [WL_W-1:0] window_for_phase(input int k);
		case (k % 12)
		0:  return 8'd0;
		1:  return 8'd16;
		2:  return 8'd1;
		3:  return 8'd17;
		4:  return 8'd2;
		5:  return 8'd255;
		6:  return 8'd3;
		7:  return WL_W'($urandom_range(4, 15));
		8:  return 8'd16;
		9:  return WL_W'($urandom_range(0, 255));
		10: return WL_W'($urandom_range(1, 16));
		default: return 8'd128;
		endcase
	endfunction

	function automatic sample_t pick_sample(input sample_t prev);
		case ($urandom_range(0, 5))
		0: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
		1: return sample_t'($urandom_range(0, 7));
		2: return prev + sample_t'($urandom_range(0, 4)) - 16'd2;
		default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int      sent;
		int      phase;
		int      n;
		logic    op;
		sample_t smp;
		arst_n             = 1'b0;
		s_if.valid         = 1'b0;
		s_if.opcode        = OP_PUSH;
		s_if.reading       = '0;
		c_if.valid         = 1'b0;
		c_if.window_length = '0;
		burst_left         = 0;
		hold_asks          = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// default window after reset: clear when empty, extremes, wrap, clear mid-run
		put_item(OP_CLEAR, 16'h1234);
		put_item(OP_PUSH, 16'h0000);
		put_item(OP_PUSH, 16'hFFFF);
		put_item(OP_PUSH, 16'hFFFF);
		put_item(OP_PUSH, 16'h0001);
		put_item(OP_PUSH, 16'h8000);
		put_item(OP_PUSH, 16'h7FFF);
		put_item(OP_PUSH, 16'hAAAA);
		put_item(OP_PUSH, 16'h5555);
		put_item(OP_PUSH, 16'd12345);
		put_item(OP_PUSH, 16'hFFFF);
		put_item(OP_CLEAR, 16'hFFFF);
		put_item(OP_PUSH, 16'd100);
		// one-sample window replaces on every push; two-sample takes the mean
		write_window(8'd1);
		put_item(OP_PUSH, 16'hFFFF);
		put_item(OP_PUSH, 16'h0000);
		put_item(OP_PUSH, 16'd77);
		write_window(8'd2);
		put_item(OP_PUSH, 16'hFFFF);
		put_item(OP_PUSH, 16'hFFFE);
		put_item(OP_PUSH, 16'h0003);

		sent  = 0;
		phase = 0;
		smp   = '0;
		hold_asks <= hold_asks + 1;
		while (sent < RANDOM_ITEMS) begin
			write_window(window_for_phase(phase));
			n = $urandom_range(40, 120);
			for (int i = 0; i < n; i++) begin
				if (phase == 6 && i == 20)
					hold_asks <= hold_asks + 1;
				op  = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_PUSH;
				smp = pick_sample(smp);
				put_item(op, smp);
			end
			sent += n;
			phase++;
		end

		settle();
		// leave room for any stray result beat to show up
		repeat (400) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
